// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define WSD_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define WSD_ASSERT(lbl, clk, rst_n, prop)
`define WSD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/wsd_pkg.sv =====
// Package: constants and result type for the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  localparam logic [3:0]  OPCODE_CLOSE    = 4'd8;
  localparam logic [6:0]  LEN_EXT16       = 7'd126;
  localparam logic [6:0]  LEN_EXT64       = 7'd127;
  localparam logic [31:0] DEFAULT_MAX_LEN = 32'd2048;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CLOSE     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic [3:0] message_opcode;
    logic       last_of_message;
    logic [1:0] status;
  } wsd_result_t;

endpackage
`default_nettype wire

// ===== hdl/websocket_frame_deframer.sv =====
// Top level of the WebSocket (RFC 6455) frame deframer.
`default_nettype none
// Takes one received byte per item and returns at most one result item per
// byte: an unmasked payload byte, an end-of-message marker for an empty final
// frame, or a status item. For every byte, header bytes included, the parser
// state updates in the accepting cycle and any result lands in a
// single output register, so one byte per clock is sustained while the output
// side keeps up. in_stall rises only while that output register is full and
// out_stall is high. Fragmented messages are joined under the first fragment's
// opcode; the last data byte of the final frame carries last_of_message.
// 127-length frames keep only the low 32 bits of the 64-bit length. A Close
// frame (status 1) or a frame longer than max_frame_length (status 2) produces
// one status item and then all further bytes are consumed silently until reset.
// cfg_wr_data is written to max_frame_length (reset value 2048) whenever
// cfg_wr_en is high; write it only while the block is idle.
module websocket_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [7:0]  out_data_byte,
  output      logic        out_has_data,
  output      logic [3:0]  out_message_opcode,
  output      logic        out_last_of_message,
  output      logic [1:0]  out_status
);
  import wsd_pkg::*;

  logic        can_load;
  logic        byte_acc;
  logic        res_vld;
  wsd_result_t res;
  wsd_result_t out_res;

  // a byte is taken whenever the output register can absorb its result
  assign in_stall = !can_load;
  assign byte_acc = in_valid && can_load;

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_acc    (byte_acc),
    .rx_byte     (in_rx_byte),
    .res_vld     (res_vld),
    .res         (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_data_byte       = out_res.data_byte;
  assign out_has_data        = out_res.has_data;
  assign out_message_opcode  = out_res.message_opcode;
  assign out_last_of_message = out_res.last_of_message;
  assign out_status          = out_res.status;

endmodule
`default_nettype wire

// ===== hdl/wsd_parser.sv =====
// Frame parser: header, length, key and payload state, one byte per item.
`default_nettype none
`include "assert_macros.svh"
module wsd_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               byte_acc,
  input  wire logic [7:0]         rx_byte,
  output      logic               res_vld,
  output      wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_KEY     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  logic [31:0] max_len_r,  max_len_nxt;
  logic [2:0]  phase_r,    phase_nxt;
  logic        final_r,    final_nxt;
  logic [3:0]  opc_r,      opc_nxt;
  logic        masked_r,   masked_nxt;
  logic [31:0] rem_r,      rem_nxt;
  logic [2:0]  hcnt_r,     hcnt_nxt;
  logic [31:0] key_r,      key_nxt;
  logic [1:0]  mpos_r,     mpos_nxt;
  logic        frag_r,     frag_nxt;
  logic [3:0]  first_op_r, first_op_nxt;
  logic        halted_r,   halted_nxt;

  logic        chk_len;
  logic [31:0] len_val;
  logic        len_masked;
  logic        chk_key;
  logic [31:0] key_len;
  logic [7:0]  key_byte;

  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    max_len_nxt  = cfg_wr_en ? cfg_wr_data : max_len_r;
    phase_nxt    = phase_r;
    final_nxt    = final_r;
    opc_nxt      = opc_r;
    masked_nxt   = masked_r;
    rem_nxt      = rem_r;
    hcnt_nxt     = hcnt_r;
    key_nxt      = key_r;
    mpos_nxt     = mpos_r;
    frag_nxt     = frag_r;
    first_op_nxt = first_op_r;
    halted_nxt   = halted_r;
    res_vld      = 1'b0;
    res          = '0;
    chk_len      = 1'b0;
    len_val      = '0;
    len_masked   = masked_r;
    chk_key      = 1'b0;
    key_len      = rem_r;

    if (byte_acc && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          final_nxt = rx_byte[7];
          opc_nxt   = rx_byte[3:0];
          if (!frag_r) first_op_nxt = rx_byte[3:0];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          if (opc_r == OPCODE_CLOSE) begin
            halted_nxt = 1'b1;
            res_vld    = 1'b1;
            res.status = STATUS_CLOSE;
          end else begin
            masked_nxt = rx_byte[7];
            hcnt_nxt   = '0;
            rem_nxt    = '0;
            if (rx_byte[6:0] == LEN_EXT16) begin
              phase_nxt = PH_EXT16;
            end else if (rx_byte[6:0] == LEN_EXT64) begin
              phase_nxt = PH_EXT64;
            end else begin
              rem_nxt    = {25'd0, rx_byte[6:0]};
              chk_len    = 1'b1;
              len_val    = {25'd0, rx_byte[6:0]};
              len_masked = rx_byte[7];
            end
          end
        end
        PH_EXT16: begin
          rem_nxt  = {16'd0, rem_r[7:0], rx_byte};
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_r == 3'd1) begin
            chk_len = 1'b1;
            len_val = {16'd0, rem_r[7:0], rx_byte};
          end
        end
        PH_EXT64: begin
          // upper four length bytes are dropped
          if (hcnt_r[2]) rem_nxt = {rem_r[23:0], rx_byte};
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_r == 3'd7) begin
            chk_len = 1'b1;
            len_val = {rem_r[23:0], rx_byte};
          end
        end
        PH_KEY: begin
          key_nxt  = {key_r[23:0], rx_byte};
          hcnt_nxt = hcnt_r + 3'd1;
          if (hcnt_r == 3'd3) begin
            chk_key = 1'b1;
            key_len = rem_r;
          end
        end
        PH_PAYLOAD: begin
          res_vld            = 1'b1;
          res.has_data       = 1'b1;
          res.data_byte      = masked_r ? (rx_byte ^ key_byte) : rx_byte;
          res.message_opcode = first_op_r;
          mpos_nxt           = mpos_r + 2'd1;
          rem_nxt            = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            phase_nxt           = PH_HDR0;
            frag_nxt            = !final_r;
            res.last_of_message = final_r;
          end
        end
        default: phase_nxt = PH_HDR0;
      endcase

      // length known: range check, then key, payload or end of an empty frame
      if (chk_len) begin
        if (len_val > max_len_r) begin
          halted_nxt = 1'b1;
          res_vld    = 1'b1;
          res.status = STATUS_TOO_LONG;
        end else if (len_masked) begin
          hcnt_nxt  = '0;
          key_nxt   = '0;
          phase_nxt = PH_KEY;
        end else begin
          chk_key = 1'b1;
          key_len = len_val;
        end
      end

      // header complete
      if (chk_key) begin
        if (key_len == 32'd0) begin
          phase_nxt = PH_HDR0;
          frag_nxt  = !final_r;
          if (final_r) begin
            res_vld             = 1'b1;
            res.message_opcode  = first_op_r;
            res.last_of_message = 1'b1;
          end
        end else begin
          mpos_nxt  = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= DEFAULT_MAX_LEN;
      phase_r    <= PH_HDR0;
      final_r    <= 1'b0;
      opc_r      <= '0;
      masked_r   <= 1'b0;
      rem_r      <= '0;
      hcnt_r     <= '0;
      key_r      <= '0;
      mpos_r     <= '0;
      frag_r     <= 1'b0;
      first_op_r <= '0;
      halted_r   <= 1'b0;
    end else begin
      max_len_r  <= max_len_nxt;
      phase_r    <= phase_nxt;
      final_r    <= final_nxt;
      opc_r      <= opc_nxt;
      masked_r   <= masked_nxt;
      rem_r      <= rem_nxt;
      hcnt_r     <= hcnt_nxt;
      key_r      <= key_nxt;
      mpos_r     <= mpos_nxt;
      frag_r     <= frag_nxt;
      first_op_r <= first_op_nxt;
      halted_r   <= halted_nxt;
    end
  end

  `WSD_ASSERT(a_halt_sticky, clk, rst_n, halted_r |=> halted_r)
  `WSD_NEVER(a_no_result_halted, clk, rst_n, halted_r && res_vld)
  `WSD_ASSERT(a_payload_rem_nonzero, clk, rst_n, (phase_r == PH_PAYLOAD) |-> (rem_r != 32'd0))

endmodule
`default_nettype wire

// ===== hdl/wsd_out_reg.sv =====
// Result register: holds one result item until the consumer takes it.
`default_nettype none
`include "assert_macros.svh"
module wsd_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 res_vld,
  input  wire wsd_pkg::wsd_result_t res,
  output      logic                 can_load,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      wsd_pkg::wsd_result_t out_res
);
  import wsd_pkg::*;

  logic        valid_r, valid_nxt;
  wsd_result_t res_r;

  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = res_vld || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  `WSD_NEVER(a_no_overwrite, clk, rst_n, res_vld && !can_load)
  `WSD_NEVER(a_status_clean, clk, rst_n,
    valid_r && (res_r.status != STATUS_OK) && (res_r.has_data || res_r.last_of_message))
  `WSD_ASSERT(a_hold_stalled, clk, rst_n,
    (valid_r && out_stall) |=> (valid_r && $stable(res_r)))

endmodule
`default_nettype wire

// ===== tb/sv/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for websocket_frame_deframer: stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // Parser phases of the predictor, in stream order.
  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_KEY, PH_PAYLOAD
  } parse_phase_t;

  // How a frame header encodes its payload length.
  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_has_data;
  logic [3:0]  out_message_opcode;
  logic        out_last_of_message;
  logic [1:0]  out_status;

  websocket_frame_deframer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_byte       (out_data_byte),
    .out_has_data        (out_has_data),
    .out_message_opcode  (out_message_opcode),
    .out_last_of_message (out_last_of_message),
    .out_status          (out_status)
  );

  always #1 clk = ~clk;

  // Stream bytes waiting for the driver, and results the parser owes us.
  logic [7:0]  pending_bytes[$];
  wsd_result_t expected_results[$];
  wsd_result_t predicted;
  wsd_result_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor: a software copy of the deframer state, stepped once per
  // accepted byte. frame_limit mirrors max_frame_length.
  // ---------------------------------------------------------------------------
  logic [31:0]  frame_limit = DEFAULT_MAX_LEN;
  parse_phase_t phase = PH_HDR0;
  logic         fin = 1'b0;
  logic [3:0]   op = '0;
  logic         masked = 1'b0;
  logic [31:0]  remaining = '0;
  logic [2:0]   hcount = '0;
  logic [31:0]  key = '0;
  logic [1:0]   kpos = '0;
  logic         frag_open = 1'b0;
  logic [3:0]   msg_op = '0;
  logic         stopped = 1'b0;

  // Frame finished: a non-final frame leaves the message open.
  function automatic logic end_frame();
    phase = PH_HDR0;
    frag_open = !fin;
    return fin;
  endfunction

  // Header and key are in; an empty frame ends here, else payload follows.
  function automatic logic key_done(output wsd_result_t r);
    r = '0;
    if (remaining == 0) begin
      r.message_opcode = msg_op;
      r.last_of_message = 1'b1;
      return end_frame();   // marker only when the frame is final
    end
    kpos = '0;
    phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Length known: the size check comes before the key is read.
  function automatic logic length_done(output wsd_result_t r);
    r = '0;
    if (remaining > frame_limit) begin
      stopped = 1'b1;
      r.status = STATUS_TOO_LONG;
      return 1'b1;
    end
    if (masked) begin
      hcount = '0;
      key = '0;
      phase = PH_KEY;
      return 1'b0;
    end
    return key_done(r);
  endfunction

  // One stream byte in; returns 1 when it yields a result item.
  function automatic logic deframe_byte(input logic [7:0] b, output wsd_result_t r);
    logic [7:0] mask_byte;
    r = '0;
    if (stopped) return 1'b0;   // halted until reset: swallow everything
    case (phase)
      PH_HDR0: begin
        fin = b[7];
        op = b[3:0];          // RSV bits ignored
        if (!frag_open) msg_op = op;
        phase = PH_HDR1;
        return 1'b0;
      end
      PH_HDR1: begin
        if (op == OPCODE_CLOSE) begin
          stopped = 1'b1;
          r.status = STATUS_CLOSE;
          return 1'b1;
        end
        masked = b[7];
        hcount = '0;
        remaining = '0;
        if (b[6:0] == LEN_EXT16) begin
          phase = PH_EXT16;
          return 1'b0;
        end
        if (b[6:0] == LEN_EXT64) begin
          phase = PH_EXT64;
          return 1'b0;
        end
        remaining = {25'd0, b[6:0]};
        return length_done(r);
      end
      PH_EXT16: begin
        remaining = {16'd0, remaining[7:0], b};
        hcount = hcount + 3'd1;
        if (hcount == 3'd2) return length_done(r);
        return 1'b0;
      end
      PH_EXT64: begin
        // upper four length bytes are dropped
        if (hcount >= 3'd4) remaining = {remaining[23:0], b};
        hcount = hcount + 3'd1;
        if (hcount == 3'd0) return length_done(r);
        return 1'b0;
      end
      PH_KEY: begin
        key = {key[23:0], b};
        hcount = hcount + 3'd1;
        if (hcount == 3'd4) return key_done(r);
        return 1'b0;
      end
      PH_PAYLOAD: begin
        mask_byte = masked ? key[8 * (3 - int'(kpos)) +: 8] : 8'h00;
        kpos = kpos + 2'd1;
        remaining = remaining - 32'd1;
        r.data_byte = b ^ mask_byte;
        r.has_data = 1'b1;
        r.message_opcode = msg_op;
        if (remaining == 0) r.last_of_message = end_frame();
        return 1'b1;
      end
      default: begin
        phase = PH_HDR0;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes, holds a byte while stalled, and feeds
  // every accepted byte to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_rx_byte, predicted)) expected_results.push_back(predicted);
      end
      // a stalled byte stays put; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_rx_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest expectation
  // and drives random back-pressure.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display({"%0t: unexpected result, expected none actual ",
                    "data %0h has %0b op %0h last %0b st %0d"},
                   $time, out_data_byte, out_has_data, out_message_opcode,
                   out_last_of_message, out_status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("has_data", 8'(want.has_data), 8'(out_has_data));
          check_field("message_opcode", 8'(want.message_opcode), 8'(out_message_opcode));
          check_field("last_of_message", 8'(want.last_of_message), 8'(out_last_of_message));
          check_field("status", 8'(want.status), 8'(out_status));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: too long without any item moving on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stream construction
  // ---------------------------------------------------------------------------
  task automatic push_header(input logic fin_b, input logic [2:0] rsv, input logic [3:0] opc,
                             input logic mask_b, input logic [31:0] len,
                             input len_form_t form, input logic [31:0] upper);
    pending_bytes.push_back({fin_b, rsv, opc});
    case (form)
      FORM_SHORT: pending_bytes.push_back({mask_b, len[6:0]});
      FORM_EXT16: begin
        pending_bytes.push_back({mask_b, LEN_EXT16});
        pending_bytes.push_back(len[15:8]);
        pending_bytes.push_back(len[7:0]);
      end
      default: begin
        pending_bytes.push_back({mask_b, LEN_EXT64});
        for (int i = 3; i >= 0; i--) pending_bytes.push_back(upper[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) pending_bytes.push_back(len[8 * i +: 8]);
      end
    endcase
    if (mask_b) repeat (4) pending_bytes.push_back(8'($urandom));
  endtask

  task automatic push_frame(input logic fin_b, input logic [2:0] rsv, input logic [3:0] opc,
                            input logic mask_b, input logic [31:0] len,
                            input len_form_t form, input logic [31:0] upper);
    push_header(fin_b, rsv, opc, mask_b, len, form, upper);
    repeat (len) pending_bytes.push_back(8'($urandom));
  endtask

  // Random frame with any opcode but Close, never over the current limit.
  // Lengths stay mostly short; long encodings are used for short lengths too.
  task automatic push_random_frame();
    int unsigned pick;
    logic [31:0] len;
    logic [3:0]  opc;
    len_form_t   form;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 0;
    else if (pick < 85) len = $urandom_range(1, 12);
    else if (pick < 97) len = $urandom_range(13, 60);
    else len = $urandom_range(100, 300);
    if (len > frame_limit) len = $urandom_range(frame_limit);
    do opc = 4'($urandom); while (opc == OPCODE_CLOSE);
    pick = $urandom_range(0, 99);
    if (len > 125) form = (pick < 70) ? FORM_EXT16 : FORM_EXT64;
    else if (pick < 60) form = FORM_SHORT;
    else if (pick < 85) form = FORM_EXT16;
    else form = FORM_EXT64;
    push_frame($urandom_range(0, 99) < 65, 3'($urandom), opc, 1'($urandom), len, form,
               32'($urandom));
  endtask

  // Sender idle / receiver stall mix for a phase.
  task automatic set_pressure(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  // Block is idle once every byte is in and every result is out; sampled on
  // the falling edge so the driver's updates have settled. A trailing wait
  // covers header bytes that make no result.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_limit = v;
  endtask

  // Change the limit, then stream random frames; a frame exactly at the
  // limit goes first when the limit is small enough to send.
  task automatic run_phase(input logic [31:0] limit, input int mode, input int budget);
    write_limit(limit);
    set_pressure(mode);
    if (frame_limit <= 300)
      push_frame(1'b1, 3'd0, 4'd2, 1'($urandom), frame_limit,
                 (frame_limit > 125) ? FORM_EXT16 : FORM_SHORT, '0);
    while (pending_bytes.size() < budget) push_random_frame();
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening at the reset limit, no idling.
    set_pressure(0);
    // all-zero header: non-final continuation, empty -> nothing out, message open
    push_frame(1'b0, 3'd0, 4'd0, 1'b0, 0, FORM_SHORT, '0);
    // Ping fragment inside the open message: its opcode must not replace the first
    push_frame(1'b0, 3'd5, 4'd9, 1'b1, 2, FORM_EXT16, '0);
    // all-ones header and length byte: final, all RSV set, 64-bit length with junk on top
    push_frame(1'b1, 3'd7, 4'd15, 1'b1, 2, FORM_EXT64, 32'hFFFF_FFFF);
    // empty final frame -> lone end marker
    push_frame(1'b1, 3'd0, 4'd2, 1'b0, 0, FORM_SHORT, '0);
    // empty final frame with key
    push_frame(1'b1, 3'd0, 4'd1, 1'b1, 0, FORM_EXT16, '0);
    push_frame(1'b1, 3'd0, 4'd1, 1'b0, 5, FORM_SHORT, '0);
    while (pending_bytes.size() < 160) push_random_frame();
    wait_idle();

    // Limit extremes and two limits in between, each phase setting a pressure mode.
    run_phase(32'hFFFF_FFFF, 1, 160);
    run_phase(32'd0, 2, 40);
    run_phase($urandom_range(1, 40), 3, 160);
    run_phase(32'd300, $urandom_range(0, 3), 120);

    // Closing act: halt the parser by Close or by an oversize frame, then
    // send bytes that must vanish.
    if ($urandom_range(0, 1)) begin
      pending_bytes.push_back({1'($urandom), 3'($urandom), OPCODE_CLOSE});
      pending_bytes.push_back(8'($urandom));
    end else begin
      push_header(1'b1, 3'd0, 4'd2, 1'($urandom), frame_limit + 1 + $urandom_range(0, 500),
                  len_form_t'($urandom_range(1, 2)), 32'($urandom));
    end
    repeat (12) pending_bytes.push_back(8'($urandom));
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer.sv
tb/sv/tb_websocket_frame_deframer.sv
